/* rtl/hbtu_pkg.sv */
// Shared types and codes for the half-bit-tick UART transceiver.
package hbtu_pkg;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_SEND = 2'd1,
        OP_ACK  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_START = 2'd1,
        MODE_DATA  = 2'd2,
        MODE_STOP  = 2'd3
    } t_mode;

    localparam int unsigned DATA_BITS = 8;
    localparam int unsigned CNT_W     = 4;
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(DATA_BITS - 1);

    typedef struct packed {
        logic tx_tick;
        logic rx_tick;
        logic load;
        logic ack;
    } t_step_ctl;

endpackage

/* rtl/hbtu_if.sv */
// Valid/ready channel interfaces for the transceiver's input and result items.
interface hbtu_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] tx_byte;
    logic       rx_line;

    modport source (output valid, output op, output tx_byte, output rx_line, input ready);
    modport sink   (input valid, input op, input tx_byte, input rx_line, output ready);
endinterface

interface hbtu_out_if;
    logic       valid;
    logic       ready;
    logic       tx_line;
    logic [7:0] rx_byte;
    logic       rx_ready;
    logic       rx_overrun;
    logic       tx_busy;

    modport source (output valid, output tx_line, output rx_byte, output rx_ready,
                    output rx_overrun, output tx_busy, input ready);
    modport sink   (input valid, input tx_line, input rx_byte, input rx_ready,
                    input rx_overrun, input tx_busy, output ready);
endinterface

/* rtl/half_bit_tick_uart_transceiver.sv */
// Half-bit-tick 8N1 UART transceiver top level.
// The result item is valid the cycle after its input item is taken.
// Throughput: one item per cycle while results are taken; the state registers double as the result register.
// A new item is taken whenever no result is pending or the pending one is taken.
// Reset (synchronous, active low): line high, both framers idle, flags and phase clear.
module half_bit_tick_uart_transceiver (
    input  logic  i_clk,
    input  logic  i_rst_n,
    hbtu_in_if.sink    i_in,
    hbtu_out_if.source o_out
);
    import hbtu_pkg::*;

    logic      r_phase;
    logic      r_valid;
    logic      in_acc;
    t_step_ctl ctl;

    assign i_in.ready = !r_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;

    always_comb begin
        ctl = '0;
        if (in_acc) begin
            unique case (t_op'(i_in.op))
                OP_TICK: begin
                    ctl.tx_tick = !r_phase;
                    ctl.rx_tick = r_phase;
                end
                OP_SEND: ctl.load = 1'b1;
                OP_ACK:  ctl.ack  = 1'b1;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (ctl.tx_tick || ctl.rx_tick) begin
                r_phase <= !r_phase;
            end
            if (in_acc) begin
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    hbtu_tx u_tx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_byte  (i_in.tx_byte),
        .o_level (o_out.tx_line),
        .o_busy  (o_out.tx_busy)
    );

    hbtu_rx u_rx (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_line    (i_in.rx_line),
        .o_byte    (o_out.rx_byte),
        .o_ready   (o_out.rx_ready),
        .o_overrun (o_out.rx_overrun)
    );

    assign o_out.valid = r_valid;

`ifndef SYNTH
    a_ack_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.ack |=> (!o_out.rx_ready && !o_out.rx_overrun))
        else $error("acknowledge did not clear flags");

    a_overrun_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.rx_overrun |-> o_out.rx_ready)
        else $error("overrun without pending byte");

    a_send_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.load |=> o_out.tx_busy)
        else $error("send did not start a frame");

    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctl.load || ctl.ack) |=> $stable(r_phase))
        else $error("phase moved on a non-tick item");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_out.valid)
        else $error("accepted item produced no result");
`endif

endmodule

/* rtl/hbtu_tx.sv */
// Transmit framer: start bit, eight data bits LSB first, stop bit.
module hbtu_tx (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hbtu_pkg::t_step_ctl i_ctl,
    input  logic [7:0]        i_byte,
    output logic              o_level,
    output logic              o_busy
);
    import hbtu_pkg::*;

    t_mode            r_mode;
    logic [7:0]       r_shift;
    logic [CNT_W-1:0] r_count;
    logic             r_level;
    logic [CNT_W-1:0] n_count;

    assign n_count = r_count + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_shift <= '0;
            r_count <= '0;
            r_level <= 1'b1;
        end else if (i_ctl.load) begin
            r_shift <= i_byte;
            r_count <= '0;
            r_mode  <= MODE_START;
        end else if (i_ctl.tx_tick) begin
            unique case (r_mode)
                MODE_START: begin
                    r_level <= 1'b0;
                    r_mode  <= MODE_DATA;
                end
                MODE_DATA: begin
                    r_level <= r_shift[0];
                    r_shift <= {1'b0, r_shift[7:1]};
                    r_count <= n_count;
                    if (n_count > LAST_BIT) begin
                        r_mode <= MODE_STOP;
                    end
                end
                MODE_STOP: begin
                    r_level <= 1'b1;
                    r_mode  <= MODE_IDLE;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_level = r_level;
    assign o_busy  = (r_mode != MODE_IDLE);

endmodule

/* rtl/hbtu_rx.sv */
// Receive deframer with holding register, ready and overrun flags.
module hbtu_rx (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hbtu_pkg::t_step_ctl i_ctl,
    input  logic              i_line,
    output logic [7:0]        o_byte,
    output logic              o_ready,
    output logic              o_overrun
);
    import hbtu_pkg::*;

    t_mode            r_mode;
    logic [7:0]       r_shift;
    logic [CNT_W-1:0] r_count;
    logic [7:0]       r_holding;
    logic             r_ready;
    logic             r_overrun;
    logic [CNT_W-1:0] n_count;
    logic [7:0]       n_bit;

    assign n_count = r_count + CNT_W'(1);
    assign n_bit   = 8'(i_line) << r_count[2:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_shift   <= '0;
            r_count   <= '0;
            r_holding <= '0;
            r_ready   <= 1'b0;
            r_overrun <= 1'b0;
        end else if (i_ctl.ack) begin
            r_ready   <= 1'b0;
            r_overrun <= 1'b0;
        end else if (i_ctl.rx_tick) begin
            unique case (r_mode)
                MODE_IDLE, MODE_START: begin
                    if (r_mode == MODE_START || !i_line) begin
                        r_shift <= '0;
                        r_count <= '0;
                        r_mode  <= MODE_DATA;
                    end
                end
                MODE_DATA: begin
                    r_shift <= r_shift | n_bit;
                    r_count <= n_count;
                    if (n_count > LAST_BIT) begin
                        r_mode <= MODE_STOP;
                    end
                end
                MODE_STOP: begin
                    r_mode <= MODE_IDLE;
                    if (i_line) begin
                        if (r_ready) begin
                            r_overrun <= 1'b1;
                        end
                        r_holding <= r_shift;
                        r_ready   <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_byte    = r_holding;
    assign o_ready   = r_ready;
    assign o_overrun = r_overrun;

endmodule

/* bench/tb.sv */
// Self-checking bench for the half-bit-tick UART transceiver: random ops, predicted pin states.
`timescale 1ns / 1ps

module tb;
    import hbtu_pkg::*;

    localparam logic [1:0]  OP_SPARE    = 2'd3;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned PLAN_ITEMS  = 1575;

    typedef struct {
        logic [1:0] op;
        logic [7:0] tx_byte;
        logic       rx_line;
        bit         drain;
    } t_uart_op;

    typedef struct packed {
        logic       tx_line;
        logic [7:0] rx_byte;
        logic       rx_ready;
        logic       rx_overrun;
        logic       tx_busy;
    } t_pin_view;

    typedef struct {
        logic           phase;
        t_mode          tx_mode;
        logic [7:0]     tx_shift;
        logic [CNT_W-1:0] tx_count;
        logic           tx_level;
        t_mode          rx_mode;
        logic [7:0]     rx_shift;
        logic [CNT_W-1:0] rx_count;
        logic [7:0]     rx_holding;
        logic           ready_flag;
        logic           overrun_flag;
    } t_uart_state;

    logic clk;
    logic rst_n;

    hbtu_in_if  in_ch ();
    hbtu_out_if out_ch ();

    half_bit_tick_uart_transceiver u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_uart_op    ops_to_send[$];
    t_pin_view   expected_pins[$];
    t_uart_state uart = '{phase: 1'b0, tx_mode: MODE_IDLE, tx_shift: '0, tx_count: '0,
                          tx_level: 1'b1, rx_mode: MODE_IDLE, rx_shift: '0, rx_count: '0,
                          rx_holding: '0, ready_flag: 1'b0, overrun_flag: 1'b0};

    int unsigned n_errors   = 0;
    int unsigned n_planned  = 0;
    int unsigned n_accepted = 0;
    logic        gen_phase  = 1'b0;

    t_uart_op    cur_op;
    int unsigned burst_left = 1;
    int unsigned gap_left   = 0;
    int unsigned window     = 0;
    int unsigned stall_mode = 0;
    logic [15:0] stall_word = 16'hFFFF;
    int unsigned idle_cycles = 0;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic log_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        n_errors++;
    endtask

    task automatic predict_pins(input t_uart_op it);
        t_pin_view v;
        case (it.op)
            OP_TICK: begin
                if (!uart.phase) begin
                    uart.phase = 1'b1;
                    case (uart.tx_mode)
                        MODE_START: begin
                            uart.tx_level = 1'b0;
                            uart.tx_mode  = MODE_DATA;
                        end
                        MODE_DATA: begin
                            uart.tx_level = uart.tx_shift[0];
                            uart.tx_shift = uart.tx_shift >> 1;
                            uart.tx_count = uart.tx_count + 1'b1;
                            if (uart.tx_count > LAST_BIT) uart.tx_mode = MODE_STOP;
                        end
                        MODE_STOP: begin
                            uart.tx_level = 1'b1;
                            uart.tx_mode  = MODE_IDLE;
                        end
                        default: ;
                    endcase
                end else begin
                    uart.phase = 1'b0;
                    case (uart.rx_mode)
                        MODE_IDLE, MODE_START: begin
                            if (uart.rx_mode == MODE_START || !it.rx_line) begin
                                uart.rx_shift = '0;
                                uart.rx_count = '0;
                                uart.rx_mode  = MODE_DATA;
                            end
                        end
                        MODE_DATA: begin
                            uart.rx_shift = uart.rx_shift |
                                            (8'(it.rx_line) << uart.rx_count[2:0]);
                            uart.rx_count = uart.rx_count + 1'b1;
                            if (uart.rx_count > LAST_BIT) uart.rx_mode = MODE_STOP;
                        end
                        default: begin
                            uart.rx_mode = MODE_IDLE;
                            if (it.rx_line) begin
                                if (uart.ready_flag) uart.overrun_flag = 1'b1;
                                uart.rx_holding = uart.rx_shift;
                                uart.ready_flag = 1'b1;
                            end
                        end
                    endcase
                end
            end
            OP_SEND: begin
                uart.tx_shift = it.tx_byte;
                uart.tx_count = '0;
                uart.tx_mode  = MODE_START;
            end
            OP_ACK: begin
                uart.ready_flag   = 1'b0;
                uart.overrun_flag = 1'b0;
            end
            default: ;
        endcase
        v.tx_line    = uart.tx_level;
        v.rx_byte    = uart.rx_holding;
        v.rx_ready   = uart.ready_flag;
        v.rx_overrun = uart.overrun_flag;
        v.tx_busy    = (uart.tx_mode != MODE_IDLE);
        expected_pins.push_back(v);
    endtask

    task automatic plan(input logic [1:0] op, input logic [7:0] b, input logic line,
                        input bit drain);
        t_uart_op it;
        it.op      = op;
        it.tx_byte = b;
        it.rx_line = line;
        it.drain   = drain;
        ops_to_send.push_back(it);
        if (op == OP_TICK) gen_phase = ~gen_phase;
        n_planned++;
    endtask

    // one receive sample: pads with a transmit-phase tick when needed
    task automatic plan_rx_sample(input logic lvl);
        if (!gen_phase) plan(OP_TICK, 8'($urandom), 1'($urandom), 1'b0);
        plan(OP_TICK, 8'($urandom), lvl, 1'b0);
    endtask

    initial begin
        logic [7:0]  frame_byte;
        bit          rx_clean;
        int unsigned pad;
        int unsigned r;
        int unsigned len;

        in_ch.valid   = 1'b0;
        in_ch.op      = OP_TICK;
        in_ch.tx_byte = 8'h00;
        in_ch.rx_line = 1'b1;
        out_ch.ready  = 1'b0;
        rst_n         = 1'b0;

        // directed: spare op, ack with nothing held, full 0xFF frame both ways
        plan(OP_SPARE, 8'hFF, 1'b1, 1'b0);
        plan(OP_ACK, 8'h00, 1'b0, 1'b0);
        plan(OP_SEND, 8'hFF, 1'b1, 1'b0);
        plan_rx_sample(1'b0);
        for (int i = 0; i < 8; i++) plan_rx_sample(1'b1);
        plan_rx_sample(1'b1);
        plan(OP_SEND, 8'h00, 1'b0, 1'b1);
        plan(OP_ACK, 8'h00, 1'b1, 1'b0);

        rx_clean = 1'b1;
        while (n_planned < PLAN_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 78) begin
                // receive frame with random contents, stop bit usually high, and interleaved ops
                if (!rx_clean) pad = 10;
                else if ($urandom_range(0, 7) == 0) pad = 12;
                else pad = $urandom_range(0, 2);
                for (int i = 0; i < pad; i++) plan_rx_sample(1'b1);
                rx_clean = 1'b1;
                if ($urandom_range(0, 9) < 4) plan(OP_SEND, 8'($urandom), 1'($urandom), 1'b0);
                frame_byte = 8'($urandom);
                for (int i = 0; i < 10; i++) begin
                    r = $urandom_range(0, 79);
                    if (r < 5) plan(OP_SEND, 8'($urandom), 1'($urandom), 1'b0);
                    else if (r < 9) plan(OP_ACK, 8'($urandom), 1'($urandom), 1'b0);
                    else if (r < 11) plan(OP_SPARE, 8'($urandom), 1'($urandom), 1'b0);
                    if (i == 0) plan_rx_sample(1'b0);
                    else if (i < 9) plan_rx_sample(frame_byte[i-1]);
                    else plan_rx_sample($urandom_range(0, 99) < 85);
                end
                if ($urandom_range(0, 1) == 0) plan(OP_ACK, 8'($urandom), 1'($urandom), 1'b0);
            end else begin
                // noise
                len = $urandom_range(4, 24);
                for (int i = 0; i < len; i++) begin
                    r = $urandom_range(0, 99);
                    plan(r < 70 ? OP_TICK : r < 82 ? OP_SEND : r < 92 ? OP_ACK : OP_SPARE,
                         8'($urandom), 1'($urandom), i == 0 && $urandom_range(0, 2) == 0);
                end
                rx_clean = 1'b0;
            end
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (n_accepted != n_planned) @(posedge clk);
        while (expected_pins.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // sender: bursts with random gaps; drain items wait for all results
    always @(posedge clk) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_pins(cur_op);
                n_accepted++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    in_ch.valid <= 1'b0;
                end else if (ops_to_send.size() != 0 &&
                             !(ops_to_send[0].drain && expected_pins.size() != 0)) begin
                    cur_op = ops_to_send.pop_front();
                    in_ch.valid   <= 1'b1;
                    in_ch.op      <= cur_op.op;
                    in_ch.tx_byte <= cur_op.tx_byte;
                    in_ch.rx_line <= cur_op.rx_line;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 60);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks results and stalls on a rotating pattern, at random or not at all
    always @(posedge clk) begin
        t_pin_view seen;
        t_pin_view want;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                seen = '{out_ch.tx_line, out_ch.rx_byte, out_ch.rx_ready,
                         out_ch.rx_overrun, out_ch.tx_busy};
                if (expected_pins.size() == 0) begin
                    log_error("result item with nothing expected");
                end else begin
                    want = expected_pins.pop_front();
                    if (seen.tx_line !== want.tx_line)
                        log_error($sformatf("tx_line %b, want %b", seen.tx_line, want.tx_line));
                    if (seen.rx_byte !== want.rx_byte)
                        log_error($sformatf("rx_byte %h, want %h", seen.rx_byte, want.rx_byte));
                    if (seen.rx_ready !== want.rx_ready)
                        log_error($sformatf("rx_ready %b, want %b",
                                            seen.rx_ready, want.rx_ready));
                    if (seen.rx_overrun !== want.rx_overrun)
                        log_error($sformatf("rx_overrun %b, want %b",
                                            seen.rx_overrun, want.rx_overrun));
                    if (seen.tx_busy !== want.tx_busy)
                        log_error($sformatf("tx_busy %b, want %b", seen.tx_busy, want.tx_busy));
                end
            end
            if (window == 0) begin
                window     = 48;
                stall_mode = $urandom_range(0, 2);
                stall_word = 16'($urandom) | 16'h0001;
            end
            window--;
            stall_word = {stall_word[14:0], stall_word[15]};
            case (stall_mode)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= stall_word[0];
                default: out_ch.ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
